// ===== rtl/core/sample_mean_stddev_stderr_assert.svh =====
// assertion macros for the sample statistics block
// both macros sample on clk and are switched off while rst_n is low
`ifndef SAMPLE_MEAN_STDDEV_STDERR_ASSERT_SVH
`define SAMPLE_MEAN_STDDEV_STDERR_ASSERT_SVH

// same-cycle implication
`define SMSD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMSD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/smsd_pkg.sv =====
// shared types and fixed widths of the sample statistics block
// no dependencies
`default_nettype none

package smsd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = 17;
  localparam int SUM_W       = 33;
  localparam int SQ_W        = 47;
  localparam int PROD_W      = 2 * SAMPLE_BITS - 1;
  localparam int MAG_W       = 32;
  localparam int ALU_W       = 64;
  localparam int NUM_W       = 63;
  localparam int D1_W        = 32;
  localparam int D2_W        = 48;
  localparam int OUT_W       = 16;
  localparam int IT_W        = 7;
  localparam int DIV_STEPS   = ALU_W;
  localparam int SQRT_STEPS  = ALU_W / 2;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
  } stats_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] y;
    logic             carry;
  } alu_rsp_t;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] std_dev;
    logic [OUT_W-1:0] std_err;
    logic [CNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic start;
    logic slot_free;
  } seq_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic clr;
  } seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/smsd_alu.sv =====
// shared 64-bit add / subtract unit used by every arithmetic step of the sequencer
// depends on smsd_pkg
`default_nettype none

module smsd_alu
  import smsd_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] res;

  // for a subtract the top bit is the borrow
  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign rsp.y     = res[ALU_W-1:0];
  assign rsp.carry = res[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/core/smsd_accum.sv =====
// count, sum and sum of squares of the current data set, one sample a cycle while upd is high
// depends on smsd_pkg
`default_nettype none

module smsd_accum
  import smsd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          clr,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output stats_t                        stats
);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SQ_W-1:0]           sq_r, sq_nxt;
  logic signed [2*SAMPLE_BITS-1:0] sq_prod;

  assign sq_prod = sample * sample;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    if (clr) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      sq_nxt  = '0;
    end else if (upd) begin
      cnt_nxt = cnt_r + 1'b1;
      sum_nxt = sum_r + SUM_W'(sample);
      // square is never negative, its top bit is always clear
      sq_nxt  = sq_r + SQ_W'(sq_prod[PROD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign stats.cnt = cnt_r;
  assign stats.sum = sum_r;
  assign stats.sq  = sq_r;

endmodule

`default_nettype wire

// ===== rtl/core/smsd_seq.sv =====
// sequencer for the end of a set: mean, variance terms, two divides, two roots
// drives the shared add / subtract unit; depends on smsd_pkg
`default_nettype none

module smsd_seq
  import smsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_ctrl_t ctrl,
  input  stats_t    stats,
  input  alu_rsp_t  alu_rsp,
  output alu_req_t  alu_req,
  output seq_stat_t stat,
  output result_t   result
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LOAD      = 4'd1;
  localparam logic [3:0] S_MEAN_PREP = 4'd2;
  localparam logic [3:0] S_MEAN_DIV  = 4'd3;
  localparam logic [3:0] S_NQ_MUL    = 4'd4;
  localparam logic [3:0] S_S2_MUL    = 4'd5;
  localparam logic [3:0] S_NUM_SUB   = 4'd6;
  localparam logic [3:0] S_D1_MUL    = 4'd7;
  localparam logic [3:0] S_D2_MUL    = 4'd8;
  localparam logic [3:0] S_VAR_PREP  = 4'd9;
  localparam logic [3:0] S_VAR_DIV   = 4'd10;
  localparam logic [3:0] S_SQ_A      = 4'd11;
  localparam logic [3:0] S_SQ_B      = 4'd12;
  localparam logic [3:0] S_SQ_C      = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  localparam logic [OUT_W-1:0] MEAN_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] MEAN_MAX = {1'b0, {(OUT_W-1){1'b1}}};

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [MAG_W-1:0] abs_r, abs_nxt;
  logic             neg_r, neg_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [ALU_W-1:0] acc_r, acc_nxt;
  logic [ALU_W-1:0] opa_r, opa_nxt;
  logic [ALU_W-1:0] opb_r, opb_nxt;
  logic [ALU_W-1:0] tmp_r, tmp_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic             pass_r, pass_nxt;
  logic             flag_r, flag_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [D1_W-1:0]  d1_r, d1_nxt;
  logic [D2_W-1:0]  d2_r, d2_nxt;
  logic [OUT_W-1:0] mean_r, mean_nxt;
  logic [OUT_W-1:0] sd_r, sd_nxt;
  logic [OUT_W-1:0] se_r, se_nxt;

  logic [ALU_W-1:0] rem_sh;
  logic [ALU_W-1:0] quo;
  logic [ALU_W-1:0] den;
  logic [CNT_W-1:0] n_dec;
  logic             last_it;

  function automatic logic [OUT_W-1:0] sat_out(input logic [ALU_W-1:0] v);
    return (|v[ALU_W-1:OUT_W]) ? '1 : v[OUT_W-1:0];
  endfunction

  // restoring divide: remainder in acc, dividend shifting out of opa as quotient shifts in
  assign rem_sh  = {acc_r[ALU_W-2:0], opa_r[ALU_W-1]};
  assign quo     = {opa_r[ALU_W-2:0], ~alu_rsp.carry};
  assign den     = pass_r ? ALU_W'(d2_r) : ALU_W'(d1_r);
  assign n_dec   = n_r - 1'b1;
  assign last_it = (it_r == IT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    abs_nxt     = abs_r;
    neg_nxt     = neg_r;
    sq_nxt      = sq_r;
    acc_nxt     = acc_r;
    opa_nxt     = opa_r;
    opb_nxt     = opb_r;
    tmp_nxt     = tmp_r;
    it_nxt      = it_r;
    pass_nxt    = pass_r;
    flag_nxt    = flag_r;
    num_nxt     = num_r;
    d1_nxt      = d1_r;
    d2_nxt      = d2_r;
    mean_nxt    = mean_r;
    sd_nxt      = sd_r;
    se_nxt      = se_r;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        n_nxt     = stats.cnt;
        neg_nxt   = stats.sum[SUM_W-1];
        abs_nxt   = stats.sum[SUM_W-1] ? MAG_W'(-stats.sum) : MAG_W'(stats.sum);
        sq_nxt    = stats.sq;
        state_nxt = S_MEAN_PREP;
      end

      // mean rounds as (2|S| + n) / 2n
      S_MEAN_PREP: begin
        alu_req.a = ALU_W'({abs_r, 1'b0});
        alu_req.b = ALU_W'(n_r);
        opa_nxt   = alu_rsp.y;
        opb_nxt   = ALU_W'({n_r, 1'b0});
        acc_nxt   = '0;
        it_nxt    = IT_W'(DIV_STEPS);
        state_nxt = S_MEAN_DIV;
      end

      S_MEAN_DIV, S_VAR_DIV: begin
        alu_req.a   = rem_sh;
        alu_req.b   = opb_r;
        alu_req.sub = 1'b1;
        acc_nxt     = alu_rsp.carry ? rem_sh : alu_rsp.y;
        opa_nxt     = quo;
        it_nxt      = it_r - 1'b1;
        if (last_it) begin
          if (state_r == S_MEAN_DIV) begin
            if (neg_r) begin
              mean_nxt = (|quo[ALU_W-1:OUT_W-1]) ? MEAN_MIN : -quo[OUT_W-1:0];
            end else begin
              mean_nxt = (|quo[ALU_W-1:OUT_W-1]) ? MEAN_MAX : quo[OUT_W-1:0];
            end
            if (n_r <= CNT_W'(1)) begin
              sd_nxt    = '0;
              se_nxt    = '0;
              state_nxt = S_DONE;
            end else begin
              acc_nxt   = '0;
              opa_nxt   = ALU_W'(sq_r);
              opb_nxt   = ALU_W'(n_r);
              it_nxt    = IT_W'(CNT_W);
              state_nxt = S_NQ_MUL;
            end
          end else begin
            // root of the rounded quotient, one result bit per pass through S_SQ_A, S_SQ_B and S_SQ_C
            opa_nxt   = quo;
            acc_nxt   = '0;
            opb_nxt   = ALU_W'(1) << (ALU_W - 2);
            it_nxt    = IT_W'(SQRT_STEPS);
            state_nxt = S_SQ_A;
          end
        end
      end

      // shift-and-add multiply, multiplier bits taken lsb first from opb
      S_NQ_MUL, S_S2_MUL, S_D1_MUL, S_D2_MUL: begin
        alu_req.a = acc_r;
        alu_req.b = opb_r[0] ? opa_r : '0;
        acc_nxt   = alu_rsp.y;
        opa_nxt   = opa_r << 1;
        opb_nxt   = opb_r >> 1;
        it_nxt    = it_r - 1'b1;
        if (last_it) begin
          case (state_r)
            S_NQ_MUL: begin
              num_nxt   = alu_rsp.y[NUM_W-1:0];
              acc_nxt   = '0;
              opa_nxt   = ALU_W'(abs_r);
              opb_nxt   = ALU_W'(abs_r);
              it_nxt    = IT_W'(MAG_W);
              state_nxt = S_S2_MUL;
            end
            S_S2_MUL: begin
              state_nxt = S_NUM_SUB;
            end
            S_D1_MUL: begin
              d1_nxt    = alu_rsp.y[D1_W-1:0];
              acc_nxt   = '0;
              opa_nxt   = alu_rsp.y;
              opb_nxt   = ALU_W'(n_r);
              it_nxt    = IT_W'(CNT_W);
              state_nxt = S_D2_MUL;
            end
            default: begin
              d2_nxt    = alu_rsp.y[D2_W-1:0];
              pass_nxt  = 1'b0;
              state_nxt = S_VAR_PREP;
            end
          endcase
        end
      end

      // n*SQ - S*S, clamped at zero
      S_NUM_SUB: begin
        alu_req.a   = ALU_W'(num_r);
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
        num_nxt     = alu_rsp.carry ? '0 : alu_rsp.y[NUM_W-1:0];
        acc_nxt     = '0;
        opa_nxt     = ALU_W'(n_r);
        opb_nxt     = ALU_W'(n_dec);
        it_nxt      = IT_W'(CNT_W);
        state_nxt   = S_D1_MUL;
      end

      // rounded divide as (2*num + den) / 2*den
      S_VAR_PREP: begin
        alu_req.a = {num_r, 1'b0};
        alu_req.b = den;
        opa_nxt   = alu_rsp.y;
        opb_nxt   = den << 1;
        acc_nxt   = '0;
        it_nxt    = IT_W'(DIV_STEPS);
        state_nxt = S_VAR_DIV;
      end

      S_SQ_A: begin
        alu_req.a = acc_r;
        alu_req.b = opb_r;
        tmp_nxt   = alu_rsp.y;
        state_nxt = S_SQ_B;
      end

      S_SQ_B: begin
        alu_req.a   = opa_r;
        alu_req.b   = tmp_r;
        alu_req.sub = 1'b1;
        flag_nxt    = ~alu_rsp.carry;
        if (!alu_rsp.carry) begin
          opa_nxt = alu_rsp.y;
        end
        state_nxt = S_SQ_C;
      end

      S_SQ_C: begin
        alu_req.a = acc_r >> 1;
        alu_req.b = flag_r ? opb_r : '0;
        acc_nxt   = alu_rsp.y;
        opb_nxt   = opb_r >> 2;
        it_nxt    = it_r - 1'b1;
        if (last_it) begin
          if (!pass_r) begin
            sd_nxt    = sat_out(alu_rsp.y);
            pass_nxt  = 1'b1;
            state_nxt = S_VAR_PREP;
          end else begin
            se_nxt    = sat_out(alu_rsp.y);
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_SQ_A;
        end
      end

      S_DONE: begin
        if (ctrl.slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    abs_r  <= abs_nxt;
    neg_r  <= neg_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    tmp_r  <= tmp_nxt;
    it_r   <= it_nxt;
    pass_r <= pass_nxt;
    flag_r <= flag_nxt;
    num_r  <= num_nxt;
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    mean_r <= mean_nxt;
    sd_r   <= sd_nxt;
    se_r   <= se_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.clr  = (state_r == S_LOAD);

  assign result.mean    = mean_r;
  assign result.std_dev = sd_r;
  assign result.std_err = se_r;
  assign result.count   = n_r;

endmodule

`default_nettype wire

// ===== rtl/core/sample_mean_stddev_stderr.sv =====
// top level of the streaming mean / standard deviation / standard error block
// depends on smsd_pkg, smsd_alu, smsd_accum, smsd_seq and the assertion macro header
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  in       | in_valid / in_ready     | in_sample (Q8.8 signed), in_last
//  out      | out_valid / out_ready   | out_mean, out_std_dev, out_std_err,
//           |                         | out_sample_count
//
// a beat that does not end a set leaves in_ready high, so such beats are taken back to back
// a beat that ends a set (last, or the 65536th sample) holds in_ready low while the sequencer
// runs on the shared 64-bit adder: 64-step divides, shift-add multiplies and root steps;
// in_ready also stays low while the output register is still full
// rst_n is synchronous and clears the accumulators, the sequencer and out_valid
// the output register lets the next set accumulate while a result waits for out_ready
`default_nettype none
`include "sample_mean_stddev_stderr_assert.svh"

module sample_mean_stddev_stderr
  import smsd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_W-1:0]       out_mean,
  output logic [OUT_W-1:0]              out_std_dev,
  output logic [OUT_W-1:0]              out_std_err,
  output logic [CNT_W-1:0]              out_sample_count
);

  stats_t    stats;
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  seq_ctrl_t ctrl;
  seq_stat_t stat;
  result_t   result;

  logic    in_beat;
  logic    end_beat;
  logic    single_set;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  assign in_beat  = in_valid && in_ready;
  // the beat that brings the count to the limit closes the set as well
  assign end_beat = in_last || (stats.cnt == CNT_W'(MAX_SAMPLES - 1));
  assign in_ready = stat.idle;

  assign ctrl.start     = in_beat && end_beat;
  assign ctrl.slot_free = !out_valid_r || out_ready;

  smsd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  smsd_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (in_beat),
    .clr    (stat.clr),
    .sample (in_sample),
    .stats  (stats)
  );

  smsd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .stats   (stats),
    .alu_rsp (alu_rsp),
    .alu_req (alu_req),
    .stat    (stat),
    .result  (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (stat.done && ctrl.slot_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_mean         = out_r.mean;
  assign out_std_dev      = out_r.std_dev;
  assign out_std_err      = out_r.std_err;
  assign out_sample_count = out_r.count;

  assign single_set = out_valid && (out_sample_count == CNT_W'(1));

  `SMSD_CHECK_NEXT(a_busy_after_end, in_beat && end_beat, !in_ready, "ready after end beat")
  `SMSD_CHECK(a_err_le_dev, out_valid, out_std_err <= out_std_dev, "std_err above std_dev")
  `SMSD_CHECK(a_single_zero, single_set, (out_std_dev | out_std_err) == '0, "single spread")
  `SMSD_CHECK(a_count_nonzero, out_valid, out_sample_count != '0, "result with zero count")

endmodule

`default_nettype wire
